>>> design/astf_pkg.sv
// shared types, constants and codes for the aging subscriber table
package astf_pkg;

	// table geometry
	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	// field widths
	localparam int ADDR_W = 32;
	localparam int PORT_W = 16;
	localparam int TIME_W = 32;
	localparam int TTL_W  = 8;
	localparam int KIND_W = 2;
	localparam int STAT_W = 2;

	localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(15);
	localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(TABLE_ENTRIES);

	// input action codes
	localparam logic ACT_REGISTER = 1'b0;
	localparam logic ACT_RELAY    = 1'b1;

	// result kind codes
	localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DEST   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

	// register outcome codes
	localparam logic [STAT_W-1:0] STAT_REFRESHED = 2'd0;
	localparam logic [STAT_W-1:0] STAT_ADDED     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

	// one table entry
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [PORT_W-1:0] port;
		logic [TIME_W-1:0] seen;
	} entry_t;

	// output register source
	typedef enum logic {
		OSEL_RESP,
		OSEL_DEST
	} osel_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_REG,
		ST_SCAN_RELAY,
		ST_RESP,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic              load_item;
		logic              scan_en;
		logic              refresh;
		logic              append;
		logic              compact_wr;
		logic              set_count;
		logic              resp_we;
		logic [KIND_W-1:0] resp_kind;
		logic [STAT_W-1:0] resp_stat;
		logic              emit_start;
		logic              emit_rd;
		logic              out_load;
		osel_t             out_sel;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic out_free;
		logic rd_vld;
		logic hit;
		logic live;
		logic idx_end;
		logic full;
		logic wr_zero;
	} sts_t;

endpackage

>>> design/astf_ctrl.sv
// controller state machine for the subscriber table
module astf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            action,
	output logic            in_ready,
	input  astf_pkg::sts_t  sts,
	output astf_pkg::cmd_t  cmd
);
	import astf_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt      = state_q;
		in_ready       = 1'b0;
		cmd            = '0;
		cmd.out_sel    = OSEL_RESP;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_nxt = (action == ACT_RELAY) ? ST_SCAN_RELAY : ST_SCAN_REG;
				end
			end
			// look for a matching client, one entry a cycle; refresh it on a hit, else append it if there is room
			ST_SCAN_REG: begin
				cmd.scan_en = 1'b1;
				if (sts.rd_vld && sts.hit) begin
					cmd.refresh   = 1'b1;
					cmd.resp_we   = 1'b1;
					cmd.resp_kind = KIND_STATUS;
					cmd.resp_stat = STAT_REFRESHED;
					state_nxt     = ST_RESP;
				end else if (!sts.rd_vld && sts.idx_end) begin
					cmd.resp_we   = 1'b1;
					cmd.resp_kind = KIND_STATUS;
					if (sts.full) begin
						cmd.resp_stat = STAT_FULL;
					end else begin
						cmd.append    = 1'b1;
						cmd.resp_stat = STAT_ADDED;
					end
					state_nxt = ST_RESP;
				end
			end
			// drop expired entries and close gaps
			ST_SCAN_RELAY: begin
				cmd.scan_en = 1'b1;
				if (sts.rd_vld && sts.live) begin
					cmd.compact_wr = 1'b1;
				end
				if (!sts.rd_vld && sts.idx_end) begin
					cmd.set_count = 1'b1;
					if (sts.wr_zero) begin
						cmd.resp_we   = 1'b1;
						cmd.resp_kind = KIND_EMPTY;
						cmd.resp_stat = STAT_REFRESHED;
						state_nxt     = ST_RESP;
					end else begin
						cmd.emit_start = 1'b1;
						state_nxt      = ST_EMIT_RD;
					end
				end
			end
			// single result of the item
			ST_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OSEL_RESP;
					state_nxt    = ST_IDLE;
				end
			end
			ST_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
				state_nxt   = ST_EMIT_LD;
			end
			// one destination per live entry
			ST_EMIT_LD: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OSEL_DEST;
					state_nxt    = sts.idx_end ? ST_IDLE : ST_EMIT_RD;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

>>> design/astf_dp.sv
// datapath: table memory, scan counters, ttl register and output register
module astf_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [astf_pkg::ADDR_W-1:0]   client_addr,
	input  logic [astf_pkg::PORT_W-1:0]   client_port,
	input  logic [astf_pkg::TIME_W-1:0]   now_seconds,
	input  logic                          cfg_we,
	input  logic [astf_pkg::TTL_W-1:0]    cfg_data,
	input  astf_pkg::cmd_t                cmd,
	output astf_pkg::sts_t                sts,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [astf_pkg::KIND_W-1:0]   kind,
	output logic [astf_pkg::STAT_W-1:0]   status,
	output logic [astf_pkg::ADDR_W-1:0]   dest_addr,
	output logic [astf_pkg::PORT_W-1:0]   dest_port,
	output logic                          last_result
);
	import astf_pkg::*;

	entry_t            mem [TABLE_ENTRIES];
	entry_t            rdata_q;
	logic [ADDR_W-1:0] addr_q;
	logic [PORT_W-1:0] port_q;
	logic [TIME_W-1:0] now_q;
	logic [TTL_W-1:0]  ttl_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  wr_q;
	logic [IDX_W-1:0]  idx_s1;
	logic              vld_s1;
	logic [KIND_W-1:0] resp_kind_q;
	logic [STAT_W-1:0] resp_stat_q;
	logic              out_valid_q;

	logic              rd_en;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	entry_t            mem_wdata;
	logic [TIME_W-1:0] age;
	logic              idx_end;

	assign idx_end = (idx_q == count_q);
	assign rd_en   = (cmd.scan_en && !idx_end) || cmd.emit_rd;
	assign age     = now_q - rdata_q.seen;

	// status to controller
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.rd_vld   = vld_s1;
	assign sts.hit      = (rdata_q.addr == addr_q) && (rdata_q.port == port_q);
	assign sts.live     = (age <= TIME_W'(ttl_q));
	assign sts.idx_end  = idx_end;
	assign sts.full     = (count_q == CNT_FULL);
	assign sts.wr_zero  = (wr_q == '0);

	// write port select
	always_comb begin
		mem_we    = cmd.refresh || cmd.append || cmd.compact_wr;
		mem_waddr = wr_q[IDX_W-1:0];
		mem_wdata = rdata_q;
		if (cmd.refresh) begin
			mem_waddr = idx_s1;
			mem_wdata = '{addr: addr_q, port: port_q, seen: now_q};
		end else if (cmd.append) begin
			mem_waddr = count_q[IDX_W-1:0];
			mem_wdata = '{addr: addr_q, port: port_q, seen: now_q};
		end
	end

	// table memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[idx_q[IDX_W-1:0]];
		end
	end

	// captured item and response code
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			addr_q <= client_addr;
			port_q <= client_port;
			now_q  <= now_seconds;
		end
		if (cmd.resp_we) begin
			resp_kind_q <= cmd.resp_kind;
			resp_stat_q <= cmd.resp_stat;
		end
		if (rd_en) begin
			idx_s1 <= idx_q[IDX_W-1:0];
		end
	end

	// ttl, fill count and scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q   <= TTL_RESET;
			count_q <= '0;
			idx_q   <= '0;
			wr_q    <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (cfg_we) begin
				ttl_q <= cfg_data;
			end
			if (cmd.append) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.set_count) begin
				count_q <= wr_q;
			end
			if (cmd.load_item || cmd.emit_start) begin
				idx_q <= '0;
			end else if (rd_en) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (cmd.load_item) begin
				wr_q <= '0;
			end else if (cmd.compact_wr) begin
				wr_q <= wr_q + CNT_W'(1);
			end
			vld_s1 <= cmd.scan_en && !idx_end && !cmd.load_item;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.out_sel)
				OSEL_DEST: begin
					kind        <= KIND_DEST;
					status      <= STAT_REFRESHED;
					dest_addr   <= rdata_q.addr;
					dest_port   <= rdata_q.port;
					last_result <= idx_end;
				end
				default: begin
					kind        <= resp_kind_q;
					status      <= resp_stat_q;
					dest_addr   <= '0;
					dest_port   <= '0;
					last_result <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	// fill count stays within the table
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("entry count beyond table size");

	// append only when there is room
	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |-> (count_q < CNT_FULL))
		else $error("append into full table");

	// compaction never overtakes the read side
	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.compact_wr |-> (vld_s1 && (wr_q <= CNT_W'(idx_s1))))
		else $error("compaction write ahead of scan");

	// refresh only on a returned entry
	a_refresh_vld: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.refresh |-> vld_s1)
		else $error("refresh without read data");

	// no result overwrites one still waiting
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten");

endmodule

>>> design/aging_subscriber_table_fanout.sv
// register: scans the entries in order; a hit refreshes the entry, a miss appends it unless the table is full
// relay: a compaction scan drops expired entries, then one destination is sent per live entry
// one item in work at a time; the output register lets the next item enter while a result waits
// reset: entry count cleared, ttl set to 15 seconds; table contents are not cleared
module aging_subscriber_table_fanout (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [astf_pkg::ADDR_W-1:0]   client_addr,
	input  logic [astf_pkg::PORT_W-1:0]   client_port,
	input  logic [astf_pkg::TIME_W-1:0]   now_seconds,
	input  logic                          cfg_we,
	input  logic [astf_pkg::TTL_W-1:0]    cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [astf_pkg::KIND_W-1:0]   kind,
	output logic [astf_pkg::STAT_W-1:0]   status,
	output logic [astf_pkg::ADDR_W-1:0]   dest_addr,
	output logic [astf_pkg::PORT_W-1:0]   dest_port,
	output logic                          last_result
);
	import astf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	astf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// table and result path
	astf_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.client_addr (client_addr),
		.client_port (client_port),
		.now_seconds (now_seconds),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.sts         (sts),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.kind        (kind),
		.status      (status),
		.dest_addr   (dest_addr),
		.dest_port   (dest_port),
		.last_result (last_result)
	);

endmodule
